// ----- rtl/ipsaw_pkg.sv -----
// Shared types and constants for the IPsec anti-replay window table.
package ipsaw_pkg;

    // Fixed field widths
    localparam int ACTION_W = 2;
    localparam int IDX_W    = 6;
    localparam int SEQ_W    = 32;
    localparam int MASK_W   = 32;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PRECHECK = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UPDATE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_OPEN     = 2'd2;

    // One window entry as stored in the table
    typedef struct packed {
        logic              replay_on;
        logic [SEQ_W-1:0]  top_seq;
        logic [MASK_W-1:0] seen_mask;
    } t_entry;

    // Result of evaluating one item against its entry
    typedef struct packed {
        logic   wr_en;
        t_entry wr_data;
        logic   rejected;
    } t_upd;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

// ----- rtl/ipsaw_update.sv -----
// Window check and update logic for one item against one table entry.
module ipsaw_update #(
    parameter int WINDOW = 32
) (
    input  logic [ipsaw_pkg::ACTION_W-1:0] i_action,
    input  logic [ipsaw_pkg::SEQ_W-1:0]    i_seq,
    input  logic                           i_enable,
    input  ipsaw_pkg::t_entry              i_entry,
    output ipsaw_pkg::t_upd                o_upd
);
    import ipsaw_pkg::*;

    localparam logic [SEQ_W-1:0] WIN = SEQ_W'(WINDOW);

    logic [SEQ_W-1:0]  seq_plus_w;
    logic [SEQ_W-1:0]  top_plus_w;
    logic [SEQ_W-1:0]  adv_dist;
    logic [SEQ_W-1:0]  back_dist;
    logic              too_old;
    logic              big_jump;
    logic              ahead;
    logic [MASK_W-1:0] shifted;
    logic [MASK_W-1:0] back_bit;

    // Distances and window bounds, all wrapping at 32 bits
    assign seq_plus_w = i_seq + WIN;
    assign top_plus_w = i_entry.top_seq + WIN;
    assign adv_dist   = i_seq - i_entry.top_seq;
    assign back_dist  = i_entry.top_seq - i_seq;
    assign too_old    = (seq_plus_w <= i_entry.top_seq);
    assign big_jump   = (i_seq >= top_plus_w);
    assign ahead      = (i_seq > i_entry.top_seq);

    // Shift the mask on advance; a distance of 32 or more empties it
    assign shifted  = (adv_dist < SEQ_W'(MASK_W)) ? (i_entry.seen_mask << adv_dist[4:0])
                                                  : '0;
    assign back_bit = (back_dist < SEQ_W'(MASK_W)) ? (MASK_W'(1) << back_dist[4:0]) : '0;

    // Decide rejection and the entry to write back
    always_comb begin
        o_upd          = '0;
        o_upd.wr_data  = i_entry;
        case (i_action)
            ACT_OPEN: begin
                o_upd.wr_en             = 1'b1;
                o_upd.wr_data.replay_on = i_enable;
                o_upd.wr_data.top_seq   = '0;
                o_upd.wr_data.seen_mask = '0;
            end
            ACT_PRECHECK: begin
                o_upd.rejected = i_entry.replay_on & too_old;
            end
            ACT_UPDATE: begin
                if (i_entry.replay_on) begin
                    if (too_old) begin
                        o_upd.rejected = 1'b1;
                    end else if (big_jump) begin
                        o_upd.wr_en             = 1'b1;
                        o_upd.wr_data.top_seq   = i_seq;
                        o_upd.wr_data.seen_mask = MASK_W'(1);
                    end else if (ahead) begin
                        o_upd.wr_en             = 1'b1;
                        o_upd.wr_data.top_seq   = i_seq;
                        o_upd.wr_data.seen_mask = shifted | MASK_W'(1);
                    end else if ((i_entry.seen_mask & back_bit) != '0) begin
                        o_upd.rejected = 1'b1;
                    end else begin
                        o_upd.wr_en             = 1'b1;
                        o_upd.wr_data.seen_mask = i_entry.seen_mask | back_bit;
                    end
                end
            end
            default: begin
                o_upd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/ipsec_antireplay_window_core.sv -----
// Top level of the IPsec anti-replay window table: table memory and sequencer.
//
// For each item, the accept edge reads the SA's entry from the single-port
// table memory into a register, and the check state then checks the window,
// writes the entry back and loads the result register, so one item is in
// flight at a time and the next read always sees the written entry. A result
// waiting at the output does not block acceptance of the next item; the item
// then holds in its check state until the output register is free. After
// reset the table is cleared one entry per cycle, and o_ready is low until
// the clear is done. An SA index at or above SA_COUNT, and the unused action
// code, leave the table alone and return rejected = 0.
module ipsec_antireplay_window_core #(
    parameter int WINDOW   = 32,
    parameter int SA_COUNT = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [ipsaw_pkg::ACTION_W-1:0] i_action,
    input  logic [ipsaw_pkg::IDX_W-1:0]    i_sa_index,
    input  logic [ipsaw_pkg::SEQ_W-1:0]    i_seq,
    input  logic                           i_enable,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_rejected
);
    import ipsaw_pkg::*;

    localparam int AW = (SA_COUNT > 1) ? $clog2(SA_COUNT) : 1;
    localparam int XW = IDX_W + AW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(SA_COUNT - 1);

    t_state r_state, n_state;

    logic [AW-1:0]       r_clr_addr;
    logic [ACTION_W-1:0] r_action;
    logic [AW-1:0]       r_addr;
    logic                r_in_range;
    logic [SEQ_W-1:0]    r_seq;
    logic                r_enable;
    logic                r_out_valid;
    logic                r_rejected;

    t_entry r_mem [SA_COUNT];
    t_entry r_rd_data;

    logic [XW-1:0] idx_ext;
    logic [AW-1:0] in_addr;
    logic          in_range;
    logic          accept;
    logic          finish;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    t_upd          upd;

    // Map the input index onto the table address space
    assign idx_ext  = XW'(i_sa_index);
    assign in_addr  = idx_ext[AW-1:0];
    assign in_range = (idx_ext < XW'(SA_COUNT));
    assign accept   = i_valid & o_ready;

    ipsaw_update #(
        .WINDOW (WINDOW)
    ) u_update (
        .i_action (r_action),
        .i_seq    (r_seq),
        .i_enable (r_enable),
        .i_entry  (r_rd_data),
        .o_upd    (upd)
    );

    // Sequencer: clearing pass, idle, check and write back
    always_comb begin
        n_state   = r_state;
        o_ready   = 1'b0;
        finish    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = upd.wr_data;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || i_ready) begin
                    finish  = 1'b1;
                    mem_we  = upd.wr_en & r_in_range;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and the clearing address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // Table memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            r_rd_data <= r_mem[in_addr];
        end
    end

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action   <= i_action;
            r_addr     <= in_addr;
            r_in_range <= in_range;
            r_seq      <= i_seq;
            r_enable   <= i_enable;
        end
    end

    // Output register: load on finish, drop on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_rejected <= upd.rejected & r_in_range;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_rejected = r_rejected;

endmodule

// ----- sim/ipsec_antireplay_window_core_test.sv -----
// Self-checking testbench for the IPsec anti-replay window table core.
`timescale 1ns / 1ps

module ipsec_antireplay_window_core_test;
    import ipsaw_pkg::*;

    localparam int WIN_LEN      = 32;
    localparam int SA_NUM       = 64;
    localparam int RAND_ITEMS   = 1800;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    // Action code that the block ignores
    localparam logic [ACTION_W-1:0] ACT_RSVD = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [ACTION_W-1:0] i_action;
    logic [IDX_W-1:0]    i_sa_index;
    logic [SEQ_W-1:0]    i_seq;
    logic                i_enable;
    logic                o_valid;
    logic                i_ready;
    logic                o_rejected;

    // Shadow copy of the window table
    logic [SEQ_W-1:0]  win_top  [SA_NUM];
    logic [MASK_W-1:0] win_mask [SA_NUM];
    logic              win_on   [SA_NUM];

    logic              expected_verdicts [$];
    int                mismatch_cnt;
    int                sent_cnt;
    bit                calm_tx;
    logic [IDX_W-1:0]  hot_sa [8];

    // One directed row: item fields, then an optional typed-in verdict
    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [IDX_W-1:0]    sa;
        logic [SEQ_W-1:0]    sq;
        logic                en;
        logic                typed;
        logic                rej;
    } t_row;

    localparam int N_DIR = 25;
    localparam t_row DIR_PLAN [N_DIR] = '{
        // disabled SA after reset accepts anything
        '{ACT_PRECHECK, 6'd0,  32'd0,          1'b0, 1'b1, 1'b0},
        '{ACT_UPDATE,   6'd0,  32'hffffffff,   1'b1, 1'b1, 1'b0},
        '{ACT_OPEN,     6'd0,  32'h12345678,   1'b1, 1'b1, 1'b0},
        // large jump, then duplicate of the top
        '{ACT_UPDATE,   6'd0,  32'd100,        1'b0, 1'b0, 1'b0},
        '{ACT_UPDATE,   6'd0,  32'd100,        1'b0, 1'b1, 1'b1},
        // fill inside the window, then replay it
        '{ACT_UPDATE,   6'd0,  32'd98,         1'b0, 1'b0, 1'b0},
        '{ACT_UPDATE,   6'd0,  32'd98,         1'b0, 1'b1, 1'b1},
        // too-old boundary on precheck
        '{ACT_PRECHECK, 6'd0,  32'd68,         1'b0, 1'b1, 1'b1},
        '{ACT_PRECHECK, 6'd0,  32'd69,         1'b0, 1'b0, 1'b0},
        // oldest slot of the window
        '{ACT_UPDATE,   6'd0,  32'd69,         1'b0, 1'b0, 1'b0},
        // small advances keep shifted bits
        '{ACT_UPDATE,   6'd0,  32'd105,        1'b0, 1'b0, 1'b0},
        '{ACT_UPDATE,   6'd0,  32'd131,        1'b0, 1'b0, 1'b0},
        // jump by exactly the window, then oldest slot again
        '{ACT_UPDATE,   6'd0,  32'd163,        1'b0, 1'b0, 1'b0},
        '{ACT_UPDATE,   6'd0,  32'd132,        1'b0, 1'b0, 1'b0},
        // wrap-around at the top of the sequence space
        '{ACT_OPEN,     6'd63, 32'hffffffff,   1'b1, 1'b1, 1'b0},
        '{ACT_UPDATE,   6'd63, 32'hffffffff,   1'b0, 1'b0, 1'b0},
        '{ACT_UPDATE,   6'd63, 32'hffffffe0,   1'b0, 1'b0, 1'b0},
        '{ACT_PRECHECK, 6'd63, 32'd5,          1'b0, 1'b0, 1'b0},
        '{ACT_UPDATE,   6'd63, 32'd0,          1'b0, 1'b0, 1'b0},
        // unused action code
        '{ACT_RSVD,     6'd5,  32'hffffffff,   1'b1, 1'b1, 1'b0},
        // open with checking off
        '{ACT_OPEN,     6'd1,  32'd0,          1'b0, 1'b1, 1'b0},
        '{ACT_UPDATE,   6'd1,  32'd7,          1'b1, 1'b1, 1'b0},
        // small advance from zero, then the slot that falls to the window edge
        '{ACT_OPEN,     6'd2,  32'd0,          1'b1, 1'b1, 1'b0},
        '{ACT_UPDATE,   6'd2,  32'd31,         1'b0, 1'b0, 1'b0},
        '{ACT_UPDATE,   6'd2,  32'd0,          1'b0, 1'b0, 1'b0}
    };

    ipsec_antireplay_window_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_sa_index (i_sa_index),
        .i_seq      (i_seq),
        .i_enable   (i_enable),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rejected (o_rejected)
    );

    // Apply one item to the shadow table and return its verdict
    function automatic logic replay_verdict(input logic [ACTION_W-1:0] act,
                                            input logic [IDX_W-1:0]    sa,
                                            input logic [SEQ_W-1:0]    sq,
                                            input logic                en);
        logic [SEQ_W-1:0]  top;
        logic [MASK_W-1:0] mask;
        logic [MASK_W-1:0] slot;
        logic [SEQ_W-1:0]  span;
        logic              stale;
        logic              rej;
        top   = win_top[sa];
        mask  = win_mask[sa];
        stale = (sq + 32'(WIN_LEN)) <= top;
        rej   = 1'b0;
        case (act)
            ACT_OPEN: begin
                win_on[sa]   = en;
                win_top[sa]  = '0;
                win_mask[sa] = '0;
            end
            ACT_PRECHECK: begin
                rej = win_on[sa] && stale;
            end
            ACT_UPDATE: begin
                if (win_on[sa]) begin
                    if (stale) begin
                        rej = 1'b1;
                    end else if (sq >= top + 32'(WIN_LEN)) begin
                        win_top[sa]  = sq;
                        win_mask[sa] = 32'd1;
                    end else if (sq > top) begin
                        span         = sq - top;
                        win_mask[sa] = ((span < 32) ? (mask << span) : '0) | 32'd1;
                        win_top[sa]  = sq;
                    end else begin
                        span = top - sq;
                        slot = (span < 32) ? (32'd1 << span) : '0;
                        if ((mask & slot) != '0)
                            rej = 1'b1;
                        else
                            win_mask[sa] = mask | slot;
                    end
                end
            end
            default: ;
        endcase
        return rej;
    endfunction

    // Offer one item, wait for its acceptance, then record its verdict
    task automatic offer_item(input logic [ACTION_W-1:0] act,
                              input logic [IDX_W-1:0]    sa,
                              input logic [SEQ_W-1:0]    sq,
                              input logic                en,
                              input logic                typed,
                              input logic                typed_rej);
        int   gap;
        logic verdict;
        if (sent_cnt % 50 == 0)
            calm_tx = ($urandom_range(0, 2) == 0);
        gap = calm_tx ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= act;
        i_sa_index <= sa;
        i_seq      <= sq;
        i_enable   <= en;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        verdict = replay_verdict(act, sa, sq, en);
        expected_verdicts.push_back(typed ? typed_rej : verdict);
        sent_cnt++;
    endtask

    // Build a random item, mostly traffic near a window on a few busy SAs
    task automatic offer_random_item();
        logic [ACTION_W-1:0] act;
        logic [IDX_W-1:0]    sa;
        logic [SEQ_W-1:0]    sq;
        logic                en;
        int                  pick;
        int                  kind;
        sa   = ($urandom_range(0, 3) != 0) ? hot_sa[$urandom_range(0, 7)]
                                           : IDX_W'($urandom_range(0, SA_NUM - 1));
        en   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        kind = $urandom_range(0, 99);
        if (kind < 5)
            sq = $urandom;
        else if (kind < 12)
            sq = win_top[sa] + 32'($urandom_range(WIN_LEN, 2 * WIN_LEN));
        else if (kind < 16)
            sq = 32'hffffffff - 32'($urandom_range(0, 40));
        else
            sq = win_top[sa] + 32'($urandom_range(0, 80)) - 32'd48;
        if (pick < 3) begin
            act = ACT_RSVD;
        end else if (pick < 9) begin
            act = ACT_OPEN;
            en  = ($urandom_range(0, 4) != 0);
        end else if (pick < 27) begin
            act = ACT_PRECHECK;
        end else begin
            act = ACT_UPDATE;
        end
        offer_item(act, sa, sq, en, 1'b0, 1'b0);
    endtask

    // Free-running clock
    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run in cycles
    initial begin : watchdog
        int unsigned cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Drain results with random stalls and one long hold-off
    initial begin : result_sink
        int   got;
        int   stall;
        bit   calm_rx;
        logic want;
        got     = 0;
        calm_rx = 1'b0;
        i_ready = 1'b0;
        forever begin
            if (got % 50 == 0)
                calm_rx = ($urandom_range(0, 2) == 0);
            if (got == HOLD_AT)
                stall = HOLD_CYCLES;
            else
                stall = calm_rx ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            if (expected_verdicts.size() == 0) begin
                $error("rejected: expected none, actual %0b", o_rejected);
                mismatch_cnt++;
            end else begin
                want = expected_verdicts.pop_front();
                if (o_rejected !== want) begin
                    $error("rejected: expected %0b, actual %0b", want, o_rejected);
                    mismatch_cnt++;
                end
            end
            got++;
        end
    end

    // Reset, directed rows, random traffic, drain, verdict
    initial begin : stimulus
        t_row row;
        mismatch_cnt = 0;
        sent_cnt     = 0;
        calm_tx      = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_action     = ACT_PRECHECK;
        i_sa_index   = '0;
        i_seq        = '0;
        i_enable     = 1'b0;
        for (int i = 0; i < SA_NUM; i++) begin
            win_top[i]  = '0;
            win_mask[i] = '0;
            win_on[i]   = 1'b0;
        end
        for (int i = 0; i < 8; i++)
            hot_sa[i] = IDX_W'($urandom_range(0, SA_NUM - 1));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        for (int i = 0; i < N_DIR; i++) begin
            row = DIR_PLAN[i];
            offer_item(row.act, row.sa, row.sq, row.en, row.typed, row.rej);
        end

        // random traffic
        for (int i = 0; i < RAND_ITEMS; i++)
            offer_random_item();
        i_valid <= 1'b0;

        // wait for outstanding results, then watch for strays
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && expected_verdicts.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
